FILE: rtl/gbp_pkg.sv
// Shared types, constants and arithmetic helpers of the Goertzel band power bank.
package gbp_pkg;

  localparam int unsigned ADC_W    = 10;
  localparam int unsigned GAIN_W   = 4;
  localparam int unsigned BAND_W   = 3;
  localparam int unsigned POW_W    = 8;
  localparam int unsigned X_W      = 18;
  localparam int unsigned ST_W     = 32;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned FRAC_W   = 15;
  localparam int unsigned POW_LSB  = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned Q_PTR_W  = 1;
  localparam int unsigned Q_CNT_W  = 2;
  localparam int unsigned Q_DEPTH  = 2;

  localparam logic [ADC_W-1:0]  BIAS_RST = ADC_W'(512);
  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIC_BIAS = 2'd0,
    CFG_MIC_GAIN = 2'd1
  } cfg_idx_e;

  // One queued sample: scaled value plus block-end marker.
  typedef struct packed {
    logic                  flush;
    logic signed [X_W-1:0] x;
  } item_t;

  // Q15 cosine of each band.
  function automatic logic [COEF_W-1:0] coef(input logic [BAND_W-1:0] b);
    logic [COEF_W-1:0] c;
    unique case (b)
      3'd0:    c = 16'd32717;
      3'd1:    c = 16'd32488;
      3'd2:    c = 16'd32138;
      3'd3:    c = 16'd31029;
      3'd4:    c = 16'd28378;
      3'd5:    c = 16'd25997;
      3'd6:    c = 16'd18205;
      default: c = 16'd8481;
    endcase
    return c;
  endfunction

  // Round a full product back to Q0: (p + 2^14) >> 15, wrapped to 32 bits.
  function automatic logic signed [ST_W-1:0] fround(input logic signed [2*ST_W-1:0] p);
    logic [ST_W+FRAC_W-1:0] r;
    r = p[ST_W+FRAC_W-1:0] + (ST_W+FRAC_W)'(1 << (FRAC_W-1));
    return $signed(r[ST_W+FRAC_W-1:FRAC_W]);
  endfunction

endpackage

FILE: rtl/gbp_front.sv
// Front end: configuration registers, sample scaling and block position tracking.
module gbp_front #(
  parameter int unsigned BLOCK_LEN = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gbp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gbp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [gbp_pkg::ADC_W-1:0]      adc_sample_i,
  output logic                           push_o,
  output gbp_pkg::item_t                 push_item_o,
  input  logic                           q_full_i
);

  localparam int unsigned CNT_W = $clog2(BLOCK_LEN);

  logic [gbp_pkg::ADC_W-1:0]  bias_q;
  logic [gbp_pkg::GAIN_W-1:0] gain_q;
  logic [CNT_W-1:0]           left_q, left_d;
  logic signed [gbp_pkg::ADC_W:0]   diff;
  logic signed [gbp_pkg::ADC_W+5:0] prod;
  logic                       accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~q_full_i;
  assign accept      = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= gbp_pkg::BIAS_RST;
      gain_q <= gbp_pkg::GAIN_RST;
    end else if (cfg_valid_i) begin
      unique case (gbp_pkg::cfg_idx_e'(cfg_index_i))
        gbp_pkg::CFG_MIC_BIAS: bias_q <= cfg_data_i[gbp_pkg::ADC_W-1:0];
        gbp_pkg::CFG_MIC_GAIN: gain_q <= cfg_data_i[gbp_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Offset-correct, gain, floor-halve, then scale by 16.
  always_comb begin
    diff = $signed({1'b0, adc_sample_i}) - $signed({1'b0, bias_q});
    prod = $signed({1'b0, gain_q}) * diff;
    push_item_o.x     = $signed({prod[14:1], 4'b0000});
    push_item_o.flush = (left_q == '0);
    left_d = (left_q == '0) ? CNT_W'(BLOCK_LEN - 2) : left_q - CNT_W'(1);
  end

  assign push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= CNT_W'(BLOCK_LEN - 1);
    end else if (accept) begin
      left_q <= left_d;
    end
  end

endmodule

FILE: rtl/gbp_queue.sv
// Two-entry queue that decouples the front end from the resonator engine.
module gbp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gbp_pkg::item_t push_item_i,
  output logic           full_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output gbp_pkg::item_t pop_item_o
);

  gbp_pkg::item_t                 mem_q [gbp_pkg::Q_DEPTH];
  logic [gbp_pkg::Q_PTR_W-1:0]    wr_q, rd_q;
  logic [gbp_pkg::Q_CNT_W-1:0]    cnt_q;
  logic                           pop;

  assign full_o      = (cnt_q == gbp_pkg::Q_CNT_W'(gbp_pkg::Q_DEPTH));
  assign pop_valid_o = (cnt_q != '0);
  assign pop         = pop_valid_o & pop_ready_i;
  assign pop_item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + gbp_pkg::Q_PTR_W'(1);
      if (pop)    rd_q <= rd_q + gbp_pkg::Q_PTR_W'(1);
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + gbp_pkg::Q_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - gbp_pkg::Q_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: rtl/gbp_engine.sv
// Resonator engine: band power readout and resonator update on one shared multiplier.
module gbp_engine #(
  parameter int unsigned NUM_BANDS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  gbp_pkg::item_t              pop_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gbp_pkg::BAND_W-1:0]  band_index_o,
  output logic [gbp_pkg::POW_W-1:0]   band_power_o,
  output logic                        last_band_o
);

  localparam int unsigned IDX_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BANDS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PA, ST_PB, ST_PC, ST_PD, ST_UPD
  } state_e;

  state_e state_q;
  logic [IDX_W-1:0] band_q;
  logic signed [gbp_pkg::ST_W-1:0] s1_q [NUM_BANDS];
  logic signed [gbp_pkg::ST_W-1:0] s2_q [NUM_BANDS];
  logic signed [gbp_pkg::X_W-1:0]  x_q;
  logic                            flush_q;
  logic signed [gbp_pkg::ST_W-1:0] acc_q, acc_d, t_q, t_d;
  logic                            out_valid_q;

  logic signed [gbp_pkg::ST_W-1:0]   s1_rd, s2_rd, s1_e, s2_e, c2, mul_a, mul_b;
  logic signed [gbp_pkg::ST_W-1:0]   fm, s_new, pw;
  logic signed [2*gbp_pkg::ST_W-1:0] prod;
  logic                              out_free, is_last;

  assign s1_rd    = s1_q[band_q];
  assign s2_rd    = s2_q[band_q];
  assign out_free = ~out_valid_q | out_ready_i;
  assign is_last  = (band_q == LAST_IDX);
  assign pop_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    c2 = $signed({15'd0, gbp_pkg::coef(gbp_pkg::BAND_W'(band_q)), 1'b0});
    // A block-end sample runs against cleared resonators.
    s1_e = flush_q ? '0 : s1_rd;
    s2_e = flush_q ? '0 : s2_rd;
    unique case (state_q)
      ST_PA:   begin mul_a = s1_rd; mul_b = s1_rd; end
      ST_PB:   begin mul_a = s2_rd; mul_b = s2_rd; end
      ST_PC:   begin mul_a = s2_rd; mul_b = c2;    end
      ST_PD:   begin mul_a = s1_rd; mul_b = t_q;   end
      default: begin mul_a = c2;    mul_b = s1_e;  end
    endcase
    prod  = mul_a * mul_b;
    fm    = gbp_pkg::fround(prod);
    acc_d = (state_q == ST_PA) ? fm : acc_q + fm;
    t_d   = fm;
    pw    = acc_q - fm;
    s_new = 32'(x_q) + fm - s2_e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      band_q       <= '0;
      out_valid_q  <= 1'b0;
      band_index_o <= '0;
      band_power_o <= '0;
      last_band_o  <= 1'b0;
      for (int i = 0; i < NUM_BANDS; i++) begin
        s1_q[i] <= '0;
        s2_q[i] <= '0;
      end
    end else begin
      if (out_ready_i && !(state_q == ST_PD && out_free)) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          band_q <= '0;
          if (pop_valid_i) state_q <= pop_item_i.flush ? ST_PA : ST_UPD;
        end
        ST_PA: state_q <= ST_PB;
        ST_PB: state_q <= ST_PC;
        ST_PC: state_q <= ST_PD;
        ST_PD: begin
          // Hold until the output register can take the band's item.
          if (out_free) begin
            out_valid_q  <= 1'b1;
            band_index_o <= gbp_pkg::BAND_W'(band_q);
            band_power_o <= pw[gbp_pkg::POW_LSB +: gbp_pkg::POW_W];
            last_band_o  <= is_last;
            if (is_last) begin
              band_q  <= '0;
              state_q <= ST_UPD;
            end else begin
              band_q  <= band_q + IDX_W'(1);
              state_q <= ST_PA;
            end
          end
        end
        ST_UPD: begin
          s1_q[band_q] <= s_new;
          s2_q[band_q] <= s1_e;
          if (is_last) begin
            state_q <= ST_IDLE;
          end else begin
            band_q <= band_q + IDX_W'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && pop_valid_i) begin
      x_q     <= pop_item_i.x;
      flush_q <= pop_item_i.flush;
    end
    if (state_q == ST_PA || state_q == ST_PB) acc_q <= acc_d;
    if (state_q == ST_PC) t_q <= t_d;
  end

endmodule

FILE: rtl/goertzel_band_power_bank_core.sv
// Flow: an accepted sample is registered in the queue and popped by the engine when it is idle;
// an update steps through every band in ST_UPD, and a block-end sample first reads out each
// band through ST_PA to ST_PD, holding in ST_PD while the output register is full. The single
// 32x32 multiplier is shared by every band and power term, so a new sample waits for the last.
// Reset: bias 512, gain 1, all resonators zero, block position BLOCK_LEN-1, queue and output
// empty. No clearing pass is needed; the resonator registers clear at once.
module goertzel_band_power_bank_core #(
  parameter int unsigned NUM_BANDS = 8,
  parameter int unsigned BLOCK_LEN = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gbp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gbp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [gbp_pkg::ADC_W-1:0]      adc_sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [gbp_pkg::BAND_W-1:0]     band_index_o,
  output logic [gbp_pkg::POW_W-1:0]      band_power_o,
  output logic                           last_band_o
);

  // Front to queue: one scaled item per accepted sample.
  logic           push;
  gbp_pkg::item_t push_item;
  logic           q_full;

  // Queue to engine.
  logic           pop_valid, pop_ready;
  gbp_pkg::item_t pop_item;

  // Scale the sample and flag the first sample of each new block.
  gbp_front #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .adc_sample_i (adc_sample_i),
    .push_o       (push),
    .push_item_o  (push_item),
    .q_full_i     (q_full)
  );

  // Hold up to two items while the engine is busy.
  gbp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_item_o  (pop_item)
  );

  // Read out band powers at block end, then advance every resonator.
  gbp_engine #(
    .NUM_BANDS (NUM_BANDS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_item_i   (pop_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .band_index_o (band_index_o),
    .band_power_o (band_power_o),
    .last_band_o  (last_band_o)
  );

  // The frame marker sits on the highest band only.
  a_last_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_band_o |-> band_index_o == gbp_pkg::BAND_W'(NUM_BANDS - 1))
    else $error("last_band on a band other than the highest");

  a_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_band_o |-> band_index_o != gbp_pkg::BAND_W'(NUM_BANDS - 1))
    else $error("highest band delivered without last_band");

  // An accepted sample must be waiting in the queue on the next cycle.
  a_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> pop_valid)
    else $error("accepted item missing from queue");

endmodule

FILE: sim/goertzel_band_power_bank_core_test.sv
// Self-checking testbench of the Goertzel band power bank core.
`timescale 1ns / 100ps

module goertzel_band_power_bank_core_test;

  localparam int NUM_BANDS     = 8;
  localparam int BLOCK_LEN     = 64;
  localparam int TARGET_ITEMS  = 370;
  localparam int MIN_FRAMES    = 5;
  // Wait after the last pending power for the engine to finish its last sample, with margin.
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD     = 600;
  localparam int CYCLE_LIMIT   = 400000;

  // Register slots that the block leaves unused; writes to them must be ignored.
  localparam logic [gbp_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [gbp_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // Q15 cosine of each band, held here independently of the package.
  localparam int BAND_COS [NUM_BANDS] = '{32717, 32488, 32138, 31029,
                                          28378, 25997, 18205, 8481};

  typedef struct {
    logic [gbp_pkg::BAND_W-1:0] band;
    logic [gbp_pkg::POW_W-1:0]  power;
    logic                       last;
  } band_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic [gbp_pkg::CFG_IDX_W-1:0]  index;
    logic [gbp_pkg::CFG_DATA_W-1:0] value;
    logic [6:0]                     reps;
    logic                           zero_power;
  } plan_row_t;

  // Directed opening: a silent frame whose powers must all read zero, then full-scale
  // drive at maximum gain in both directions, zero gain, and writes to unused slots.
  localparam int PLAN_LEN = 13;
  localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
    '{ROW_SAMPLE, '0,                    10'd512,  7'd63, 1'b0},
    '{ROW_SAMPLE, '0,                    10'd512,  7'd1,  1'b1},
    '{ROW_WRITE,  gbp_pkg::CFG_MIC_GAIN, 10'd15,   7'd1,  1'b0},
    '{ROW_WRITE,  gbp_pkg::CFG_MIC_BIAS, 10'd0,    7'd1,  1'b0},
    '{ROW_SAMPLE, '0,                    10'd1023, 7'd8,  1'b0},
    '{ROW_WRITE,  gbp_pkg::CFG_MIC_BIAS, 10'd1023, 7'd1,  1'b0},
    '{ROW_SAMPLE, '0,                    10'd0,    7'd8,  1'b0},
    '{ROW_SAMPLE, '0,                    10'd1023, 7'd1,  1'b0},
    '{ROW_WRITE,  gbp_pkg::CFG_MIC_GAIN, 10'd0,    7'd1,  1'b0},
    '{ROW_SAMPLE, '0,                    10'h2AA,  7'd2,  1'b0},
    '{ROW_SAMPLE, '0,                    10'h155,  7'd2,  1'b0},
    '{ROW_WRITE,  CFG_SPARE_A,           10'h3FF,  7'd1,  1'b0},
    '{ROW_WRITE,  CFG_SPARE_B,           10'h000,  7'd1,  1'b0}
  };

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [gbp_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [gbp_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic [gbp_pkg::ADC_W-1:0]      adc_sample_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [gbp_pkg::BAND_W-1:0]     band_index_o;
  logic [gbp_pkg::POW_W-1:0]      band_power_o;
  logic                           last_band_o;

  // Shadow copy of the block: registers, resonators and block position.
  logic [gbp_pkg::ADC_W-1:0]       bias_shadow;
  logic [gbp_pkg::GAIN_W-1:0]      gain_shadow;
  logic signed [gbp_pkg::ST_W-1:0] res_s1 [NUM_BANDS];
  logic signed [gbp_pkg::ST_W-1:0] res_s2 [NUM_BANDS];
  logic [5:0]                      block_left;

  band_result_t pending_powers [$];
  band_result_t seen_expect;

  int  mismatches;
  int  samples_sent;
  int  frames_flushed;
  int  results_seen;
  int  cycle_count;
  int  rx_stall;
  bit  long_hold_done;
  bit  burst_mode;
  bit  fed_since_idle;

  goertzel_band_power_bank_core #(
    .NUM_BANDS (NUM_BANDS),
    .BLOCK_LEN (BLOCK_LEN)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .adc_sample_i (adc_sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .band_index_o (band_index_o),
    .band_power_o (band_power_o),
    .last_band_o  (last_band_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Q15 product with rounding: exact product, add half an LSB, floor shift, keep 32 bits.
  function automatic logic signed [gbp_pkg::ST_W-1:0] q15_mul(input logic signed [63:0] a,
                                                              input logic signed [63:0] b);
    logic signed [63:0] r;
    r = a * b + 64'sd16384;
    return r[46:15];
  endfunction

  // Advance the shadow by one sample; queue the band powers when it closes a block.
  task automatic predict_sample(input logic [gbp_pkg::ADC_W-1:0] adc);
    int                              scaled;
    logic signed [63:0]              twice_cos;
    logic signed [gbp_pkg::ST_W-1:0] x;
    logic signed [gbp_pkg::ST_W-1:0] pw;
    logic signed [gbp_pkg::ST_W-1:0] nxt;
    band_result_t                    res;
    if (block_left == 0) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        twice_cos = 2 * BAND_COS[b];
        pw = q15_mul(res_s1[b], res_s1[b]) + q15_mul(res_s2[b], res_s2[b])
             - q15_mul(res_s1[b], q15_mul(res_s2[b], twice_cos));
        res.band  = gbp_pkg::BAND_W'(b);
        res.power = pw[gbp_pkg::POW_LSB+gbp_pkg::POW_W-1:gbp_pkg::POW_LSB];
        res.last  = (b == NUM_BANDS - 1);
        pending_powers.push_back(res);
        res_s1[b] = '0;
        res_s2[b] = '0;
      end
      block_left = 6'(BLOCK_LEN - 1);
      frames_flushed++;
    end
    scaled = int'(gain_shadow) * (int'(adc) - int'(bias_shadow));
    x = (scaled >>> 1) * 16;
    for (int b = 0; b < NUM_BANDS; b++) begin
      twice_cos = 2 * BAND_COS[b];
      nxt = x + q15_mul(twice_cos, res_s1[b]) - res_s2[b];
      res_s2[b] = res_s1[b];
      res_s1[b] = nxt;
    end
    block_left = block_left - 6'd1;
  endtask

  // Mostly short gaps, now and then a long one; none at all in a burst phase.
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one sample and hold it until the core takes it.
  task automatic send_sample(input logic [gbp_pkg::ADC_W-1:0] adc);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    adc_sample_i <= adc;
    do @(posedge clk_i); while (!in_ready_o);
    predict_sample(adc);
    samples_sent++;
    fed_since_idle = 1'b1;
  endtask

  // Stop feeding, drain every pending power, then let the engine finish its last sample.
  task automatic drain_core();
    in_valid_i <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    fed_since_idle = 1'b0;
  endtask

  // Write one register with the core idle, and mirror it in the shadow.
  task automatic write_reg(input logic [gbp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gbp_pkg::CFG_DATA_W-1:0] data);
    if (fed_since_idle) drain_core();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == gbp_pkg::CFG_MIC_BIAS) begin
      bias_shadow = data;
    end else if (idx == gbp_pkg::CFG_MIC_GAIN) begin
      gain_shadow = data[gbp_pkg::GAIN_W-1:0];
    end
    @(posedge clk_i);
  endtask

  function automatic logic [gbp_pkg::ADC_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      2: begin
        return gbp_pkg::ADC_W'(int'(bias_shadow) + $urandom_range(0, 15) - 8);
      end
      default: begin
        return gbp_pkg::ADC_W'($urandom_range(0, 1023));
      end
    endcase
  endfunction

  function automatic logic [gbp_pkg::ADC_W-1:0] pick_bias();
    case ($urandom_range(0, 4))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      2: begin
        return gbp_pkg::BIAS_RST;
      end
      default: begin
        return gbp_pkg::ADC_W'($urandom_range(0, 1023));
      end
    endcase
  endfunction

  // Gain travels in the low bits; fill the upper data bits at random, the core drops them.
  function automatic logic [gbp_pkg::CFG_DATA_W-1:0] pick_gain_word();
    logic [gbp_pkg::GAIN_W-1:0] g;
    case ($urandom_range(0, 4))
      0: begin
        g = '0;
      end
      1: begin
        g = '1;
      end
      2: begin
        g = gbp_pkg::GAIN_RST;
      end
      default: begin
        g = gbp_pkg::GAIN_W'($urandom_range(0, 15));
      end
    endcase
    return {(gbp_pkg::CFG_DATA_W - gbp_pkg::GAIN_W)'($urandom_range(0, 63)), g};
  endfunction

  // Stimulus: reset, directed plan, then random phases each opened by fresh settings.
  initial begin
    plan_row_t row;
    int        phase_len;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    adc_sample_i   = '0;
    bias_shadow    = gbp_pkg::BIAS_RST;
    gain_shadow    = gbp_pkg::GAIN_RST;
    block_left     = 6'(BLOCK_LEN - 1);
    mismatches     = 0;
    samples_sent   = 0;
    frames_flushed = 0;
    fed_since_idle = 1'b0;
    for (int b = 0; b < NUM_BANDS; b++) begin
      res_s1[b] = '0;
      res_s2[b] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PLAN_LEN; i++) begin
      row = DIRECTED_PLAN[i];
      if (row.kind == ROW_WRITE) begin
        write_reg(row.index, row.value);
      end else begin
        for (int k = 0; k < int'(row.reps); k++) send_sample(row.value[gbp_pkg::ADC_W-1:0]);
        // A silent frame at reset settings: every band power reads zero.
        if (row.zero_power) begin
          for (int k = 0; k < NUM_BANDS; k++) pending_powers[$-k].power = '0;
        end
      end
    end

    while (samples_sent < TARGET_ITEMS || frames_flushed < MIN_FRAMES) begin
      write_reg(gbp_pkg::CFG_MIC_BIAS, gbp_pkg::CFG_DATA_W'(pick_bias()));
      write_reg(gbp_pkg::CFG_MIC_GAIN, pick_gain_word());
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                  gbp_pkg::CFG_DATA_W'($urandom_range(0, 1023)));
      end
      burst_mode <= ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 130);
      // Trim the last phase so the run ends near the target count.
      if (samples_sent < TARGET_ITEMS && phase_len > TARGET_ITEMS - samples_sent) begin
        phase_len = TARGET_ITEMS - samples_sent;
      end
      for (int k = 0; k < phase_len; k++) send_sample(pick_sample());
    end

    drain_core();
    if (mismatches == 0) begin
      $display("goertzel_band_power_bank_core test passed");
    end else begin
      $display("goertzel_band_power_bank_core test failed");
    end
    $finish;
  end

  // Result side ready: random stalls, none in a burst phase, plus one long hold-off once the
  // sender is busy mid-frame, so the queue fills and the input stalls behind it.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall    <= rx_stall - 1;
      out_ready_i <= 1'b0;
    end else if (!long_hold_done && results_seen >= 20 && in_valid_i) begin
      long_hold_done <= 1'b1;
      rx_stall       <= LONG_HOLD;
      out_ready_i    <= 1'b0;
    end else if (burst_mode) begin
      out_ready_i <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          out_ready_i <= 1'b0;
          rx_stall    <= $urandom_range(0, 3);
        end
        4: begin
          out_ready_i <= 1'b0;
          rx_stall    <= $urandom_range(10, 60);
        end
        default: begin
          out_ready_i <= 1'b1;
        end
      endcase
    end
  end

  // Compare every accepted band power with the oldest one pending.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen <= results_seen + 1;
      if (pending_powers.size() == 0) begin
        $error("band result with none pending: band_index %0d band_power %0d last_band %0d",
               band_index_o, band_power_o, last_band_o);
        mismatches++;
      end else begin
        seen_expect = pending_powers.pop_front();
        if (band_index_o !== seen_expect.band) begin
          $error("band_index: expected %0d, got %0d", seen_expect.band, band_index_o);
          mismatches++;
        end
        if (band_power_o !== seen_expect.power) begin
          $error("band_power: expected %0d, got %0d", seen_expect.power, band_power_o);
          mismatches++;
        end
        if (last_band_o !== seen_expect.last) begin
          $error("last_band: expected %0d, got %0d", seen_expect.last, last_band_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: give up on a hung core.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("goertzel_band_power_bank_core test failed");
      $finish;
    end
  end

  initial begin
    cycle_count    = 0;
    results_seen   = 0;
    rx_stall       = 0;
    long_hold_done = 1'b0;
    burst_mode     = 1'b0;
    out_ready_i    = 1'b0;
  end

endmodule
